[src/plnp_pkg.sv]
// shared types, constants and helpers of the plane normalize and project point block
package plnp_pkg;

   // coordinate format of the ports, signed q16.16
   localparam int COORD_BITS = 32;
   localparam int SAT_BITS   = (COORD_BITS < 32) ? COORD_BITS : 32;
   localparam int FIELD_BITS = 32;

   // normalized plane: unit normal in q1.30, offset in q16.16 with extended range
   localparam int NORM_BITS = 32;
   localparam int OFS_BITS  = 50;

   // csr map: four 32-bit registers at byte address 4*i
   localparam int CSR_ADDR_BITS = 4;

   localparam logic signed [FIELD_BITS-1:0] COEF_C_RESET = 32'sd65536;
   localparam logic signed [NORM_BITS-1:0]  ONE_Q30      = 32'sd1073741824;

   typedef enum logic [1:0] {
      REG_COEF_A = 2'd0,
      REG_COEF_B = 2'd1,
      REG_COEF_C = 2'd2,
      REG_COEF_D = 2'd3
   } reg_index_type;

   // normalized plane as seen by the point datapath
   typedef struct packed {
      logic signed [NORM_BITS-1:0] nx;
      logic signed [NORM_BITS-1:0] ny;
      logic signed [NORM_BITS-1:0] nz;
      logic signed [OFS_BITS-1:0]  nd;
      logic                        degen;
      logic                        busy;
   } plnp_norm_type;

   localparam int WIDE_BITS = 53;
   localparam logic signed [WIDE_BITS-1:0] SAT_MAX =
      (53'sd1 <<< (SAT_BITS - 1)) - 53'sd1;
   localparam logic signed [WIDE_BITS-1:0] SAT_MIN = -SAT_MAX - 53'sd1;

   // clip to the output range, returns {clipped, value}
   function automatic logic [FIELD_BITS:0] sat_coord(input logic signed [WIDE_BITS-1:0] v);
      logic                        clip;
      logic signed [WIDE_BITS-1:0] r;
      clip = 1'b0;
      r    = v;
      if (v > SAT_MAX) begin
         r    = SAT_MAX;
         clip = 1'b1;
      end
      if (v < SAT_MIN) begin
         r    = SAT_MIN;
         clip = 1'b1;
      end
      return {clip, r[FIELD_BITS-1:0]};
   endfunction

endpackage

[src/plnp_req_if.sv]
// request channel carrying one query point
interface plnp_req_if;
   logic                                      valid;
   logic                                      ready;
   logic signed [plnp_pkg::FIELD_BITS-1:0]    query_x;
   logic signed [plnp_pkg::FIELD_BITS-1:0]    query_y;
   logic signed [plnp_pkg::FIELD_BITS-1:0]    query_z;

   modport source (output valid, output query_x, output query_y, output query_z,
                   input ready);
   modport sink (input valid, input query_x, input query_y, input query_z,
                 output ready);
endinterface

[src/plnp_rsp_if.sv]
// result channel carrying one projected point
interface plnp_rsp_if;
   logic                                      valid;
   logic                                      ready;
   logic signed [plnp_pkg::FIELD_BITS-1:0]    proj_x;
   logic signed [plnp_pkg::FIELD_BITS-1:0]    proj_y;
   logic signed [plnp_pkg::FIELD_BITS-1:0]    proj_z;
   logic signed [plnp_pkg::FIELD_BITS-1:0]    signed_distance;
   logic                                      degenerate;
   logic                                      saturated;

   modport source (output valid, output proj_x, output proj_y, output proj_z,
                   output signed_distance, output degenerate, output saturated,
                   input ready);
   modport sink (input valid, input proj_x, input proj_y, input proj_z,
                 input signed_distance, input degenerate, input saturated,
                 output ready);
endinterface

[src/plnp_norm.sv]
// plane normalizer: sum of squares, bit-serial square root, four serial divisions
module plnp_norm (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   input  logic signed [plnp_pkg::FIELD_BITS-1:0]   coef_a,
   input  logic signed [plnp_pkg::FIELD_BITS-1:0]   coef_b,
   input  logic signed [plnp_pkg::FIELD_BITS-1:0]   coef_c,
   input  logic signed [plnp_pkg::FIELD_BITS-1:0]   coef_d,
   output plnp_pkg::plnp_norm_type                  norm
);
   import plnp_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_CHECK,
      ST_ROOT,
      ST_LOAD,
      ST_DIVIDE
   } state_type;

   state_type                   state_ff, state_in;
   logic [5:0]                  cnt_ff, cnt_in;
   logic [1:0]                  sel_ff, sel_in;
   logic [63:0]                 acc_ff, acc_in;
   logic [33:0]                 rem_ff, rem_in;
   logic [31:0]                 root_ff, root_in;
   logic [63:0]                 num_ff, num_in;
   logic signed [NORM_BITS-1:0] nx_ff, nx_in, ny_ff, ny_in, nz_ff, nz_in;
   logic signed [OFS_BITS-1:0]  nd_ff, nd_in;
   logic                        degen_ff, degen_in;

   logic signed [FIELD_BITS-1:0] coef_sel;
   logic [31:0]                  mag;
   logic [63:0]                  sq;
   logic [35:0]                  root_rt, root_trial;
   logic [33:0]                  div_rt;
   logic                         div_bit;
   logic [63:0]                  quo_next, quo_signed;

   always_comb begin
      case (reg_index_type'(sel_ff))
         REG_COEF_A: coef_sel = coef_a;
         REG_COEF_B: coef_sel = coef_b;
         REG_COEF_C: coef_sel = coef_c;
         REG_COEF_D: coef_sel = coef_d;
         default:    coef_sel = coef_a;
      endcase
      mag = coef_sel[FIELD_BITS-1] ? 32'(-coef_sel) : 32'(coef_sel);
      sq  = 64'(mag) * 64'(mag);

      // one result bit per cycle, two radicand bits consumed
      root_rt    = {rem_ff, acc_ff[63:62]};
      root_trial = {2'b00, root_ff, 2'b01};

      // restoring division by the length held in root_ff
      div_rt   = {rem_ff[32:0], num_ff[63]};
      div_bit  = (div_rt >= {2'b00, root_ff});
      quo_next = {num_ff[62:0], div_bit};
      quo_signed = coef_sel[FIELD_BITS-1] ? -quo_next : quo_next;

      state_in = state_ff;
      cnt_in   = cnt_ff;
      sel_in   = sel_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      num_in   = num_ff;
      nx_in    = nx_ff;
      ny_in    = ny_ff;
      nz_in    = nz_ff;
      nd_in    = nd_ff;
      degen_in = degen_ff;

      if (start) begin
         state_in = ST_SQUARE;
         sel_in   = 2'd0;
         acc_in   = '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
            end
            ST_SQUARE: begin
               acc_in = acc_ff + sq;
               if (sel_ff == 2'd2) begin
                  state_in = ST_CHECK;
                  sel_in   = 2'd0;
               end else begin
                  sel_in = sel_ff + 2'd1;
               end
            end
            ST_CHECK: begin
               if (acc_ff == '0) begin
                  nx_in    = '0;
                  ny_in    = '0;
                  nz_in    = '0;
                  nd_in    = '0;
                  degen_in = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_ROOT;
                  cnt_in   = '0;
                  rem_in   = '0;
                  root_in  = '0;
               end
            end
            ST_ROOT: begin
               if (root_rt >= root_trial) begin
                  rem_in  = 34'(root_rt - root_trial);
                  root_in = {root_ff[30:0], 1'b1};
               end else begin
                  rem_in  = 34'(root_rt);
                  root_in = {root_ff[30:0], 1'b0};
               end
               acc_in = {acc_ff[61:0], 2'b00};
               cnt_in = cnt_ff + 6'd1;
               if (cnt_ff == 6'd31) begin
                  state_in = ST_LOAD;
                  sel_in   = 2'd0;
               end
            end
            ST_LOAD: begin
               // normal components scaled to q1.30, offset stays q16.16
               if (reg_index_type'(sel_ff) == REG_COEF_D) begin
                  num_in = 64'(mag) << 16;
               end else begin
                  num_in = 64'(mag) << 30;
               end
               rem_in   = '0;
               cnt_in   = '0;
               state_in = ST_DIVIDE;
            end
            ST_DIVIDE: begin
               rem_in = div_bit ? 34'(div_rt - {2'b00, root_ff}) : div_rt;
               num_in = quo_next;
               cnt_in = cnt_ff + 6'd1;
               if (cnt_ff == 6'd63) begin
                  case (reg_index_type'(sel_ff))
                     REG_COEF_A: nx_in = quo_signed[NORM_BITS-1:0];
                     REG_COEF_B: ny_in = quo_signed[NORM_BITS-1:0];
                     REG_COEF_C: nz_in = quo_signed[NORM_BITS-1:0];
                     REG_COEF_D: nd_in = quo_signed[OFS_BITS-1:0];
                     default:    nx_in = nx_ff;
                  endcase
                  if (sel_ff == 2'd3) begin
                     degen_in = 1'b0;
                     state_in = ST_IDLE;
                  end else begin
                     sel_in   = sel_ff + 2'd1;
                     state_in = ST_LOAD;
                  end
               end
            end
            default: state_in = ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         sel_ff   <= '0;
         nx_ff    <= '0;
         ny_ff    <= '0;
         nz_ff    <= ONE_Q30;
         nd_ff    <= '0;
         degen_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         sel_ff   <= sel_in;
         nx_ff    <= nx_in;
         ny_ff    <= ny_in;
         nz_ff    <= nz_in;
         nd_ff    <= nd_in;
         degen_ff <= degen_in;
      end
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      num_ff  <= num_in;
   end

   assign norm.nx    = nx_ff;
   assign norm.ny    = ny_ff;
   assign norm.nz    = nz_ff;
   assign norm.nd    = nd_ff;
   assign norm.degen = degen_ff;
   assign norm.busy  = (state_ff != ST_IDLE);

endmodule

[src/plane_normalize_and_project_point_core.sv]
// top level of the plane normalize and project point block
// takes one query point per clock and returns its signed distance to the configured plane
// and its orthogonal projection onto it, all signed q16.16 and clipped to 32 bits. the
// point datapath is a nine-stage pipeline (input, multiply, dot sum, round, add offset,
// split multiply, partial sum, round, subtract and clip), taking one request per cycle
// when not stalled; stages with room keep moving while the response side stalls. a csr
// write to any coefficient restarts the normalizer (three squares, 32-step square root,
// four 64-step divisions) and no request is taken until it has finished. a zero-length
// normal gives a zero normal and offset, so points pass through and degenerate is set
module plane_normalize_and_project_point_core (
   input  logic                                     clock,
   input  logic                                     reset,
   plnp_req_if.sink                                 req_ch,
   plnp_rsp_if.source                               rsp_ch,
   input  logic                                     psel,
   input  logic                                     penable,
   input  logic                                     pwrite,
   input  logic [plnp_pkg::CSR_ADDR_BITS-1:0]       paddr,
   input  logic [31:0]                              pwdata,
   output logic [31:0]                              prdata,
   output logic                                     pready
);
   import plnp_pkg::*;

   localparam int STAGES = 9;

   // csr registers
   logic signed [FIELD_BITS-1:0] coef_a_ff, coef_b_ff, coef_c_ff, coef_d_ff;
   logic                         csr_write;
   reg_index_type                csr_reg;
   plnp_norm_type                norm;

   // pipeline control
   logic [STAGES-1:0] v_ff;
   logic [STAGES-1:0] adv;
   logic              accept;

   // stage payloads
   logic signed [FIELD_BITS-1:0] x_ff   [STAGES-1][3];
   logic signed [63:0]           m1_ff  [3];
   logic signed [63:0]           dot2_ff;
   logic signed [33:0]           r3_ff;
   logic signed [OFS_BITS-1:0]   dist4_ff, dist5_ff, dist6_ff, dist7_ff;
   logic signed [57:0]           pl5_ff [3];
   logic signed [56:0]           ph5_ff [3];
   logic signed [81:0]           p6_ff  [3];
   logic signed [51:0]           q7_ff  [3];
   logic signed [NORM_BITS-1:0]  nvec   [3];

   logic [63:0]             dot_rnd;
   logic [81:0]             p_rnd  [3];
   logic [FIELD_BITS:0]     sat_p  [3];
   logic [FIELD_BITS:0]     sat_d;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;
   assign csr_reg   = reg_index_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_a_ff <= '0;
         coef_b_ff <= '0;
         coef_c_ff <= COEF_C_RESET;
         coef_d_ff <= '0;
      end else if (csr_write) begin
         case (csr_reg)
            REG_COEF_A: coef_a_ff <= pwdata;
            REG_COEF_B: coef_b_ff <= pwdata;
            REG_COEF_C: coef_c_ff <= pwdata;
            REG_COEF_D: coef_d_ff <= pwdata;
            default:    coef_a_ff <= coef_a_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_reg)
         REG_COEF_A: prdata = coef_a_ff;
         REG_COEF_B: prdata = coef_b_ff;
         REG_COEF_C: prdata = coef_c_ff;
         REG_COEF_D: prdata = coef_d_ff;
         default:    prdata = '0;
      endcase
   end

   // normalizer restarts on every coefficient write
   plnp_norm u_norm (
      .clock  (clock),
      .reset  (reset),
      .start  (csr_write),
      .coef_a (coef_a_ff),
      .coef_b (coef_b_ff),
      .coef_c (coef_c_ff),
      .coef_d (coef_d_ff),
      .norm   (norm)
   );

   assign nvec[0] = norm.nx;
   assign nvec[1] = norm.ny;
   assign nvec[2] = norm.nz;

   // a stage moves when it is empty or the one after it moves
   always_comb begin
      adv[STAGES-1] = !v_ff[STAGES-1] || rsp_ch.ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
   end

   assign req_ch.ready = adv[0] && !norm.busy && !csr_write;
   assign accept       = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[0]) begin
            v_ff[0] <= accept;
         end
         for (int k = 1; k < STAGES; k++) begin
            if (adv[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // round to q16.16 with ties away from zero: add half, less one when negative
   assign dot_rnd = dot2_ff + 64'h0000_0000_2000_0000 - {63'b0, dot2_ff[63]};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p_rnd[i] = p6_ff[i] + 82'h2000_0000 - {81'b0, p6_ff[i][81]};
         sat_p[i] = sat_coord(53'(x_ff[STAGES-2][i]) - 53'(q7_ff[i]));
      end
      sat_d = sat_coord(53'(dist7_ff));
   end

   always_ff @(posedge clock) begin
      // stage 0: query point
      if (adv[0]) begin
         x_ff[0][0] <= req_ch.query_x;
         x_ff[0][1] <= req_ch.query_y;
         x_ff[0][2] <= req_ch.query_z;
      end
      // coordinates travel alongside the arithmetic
      for (int k = 1; k < STAGES - 1; k++) begin
         if (adv[k]) begin
            x_ff[k] <= x_ff[k-1];
         end
      end
      // stage 1: normal times point, one multiplier per axis
      if (adv[1]) begin
         for (int i = 0; i < 3; i++) begin
            m1_ff[i] <= 64'(nvec[i]) * 64'(x_ff[0][i]);
         end
      end
      // stage 2: dot product
      if (adv[2]) begin
         dot2_ff <= m1_ff[0] + m1_ff[1] + m1_ff[2];
      end
      // stage 3: back to q16.16
      if (adv[3]) begin
         r3_ff <= dot_rnd[63:30];
      end
      // stage 4: full-width distance
      if (adv[4]) begin
         dist4_ff <= OFS_BITS'(r3_ff) + norm.nd;
      end
      // stage 5: normal times distance, cut into low and high halves
      if (adv[5]) begin
         for (int i = 0; i < 3; i++) begin
            pl5_ff[i] <= 58'(nvec[i]) * 58'($signed({1'b0, dist4_ff[24:0]}));
            ph5_ff[i] <= 57'(nvec[i]) * 57'($signed(dist4_ff[49:25]));
         end
         dist5_ff <= dist4_ff;
      end
      // stage 6: join the partial products
      if (adv[6]) begin
         for (int i = 0; i < 3; i++) begin
            p6_ff[i] <= (82'(ph5_ff[i]) <<< 25) + 82'(pl5_ff[i]);
         end
         dist6_ff <= dist5_ff;
      end
      // stage 7: round the correction to q16.16
      if (adv[7]) begin
         for (int i = 0; i < 3; i++) begin
            q7_ff[i] <= p_rnd[i][81:30];
         end
         dist7_ff <= dist6_ff;
      end
      // stage 8: subtract, clip and hold the response
      if (adv[8]) begin
         rsp_ch.proj_x          <= sat_p[0][FIELD_BITS-1:0];
         rsp_ch.proj_y          <= sat_p[1][FIELD_BITS-1:0];
         rsp_ch.proj_z          <= sat_p[2][FIELD_BITS-1:0];
         rsp_ch.signed_distance <= sat_d[FIELD_BITS-1:0];
         rsp_ch.degenerate      <= norm.degen;
         rsp_ch.saturated       <= sat_p[0][FIELD_BITS] | sat_p[1][FIELD_BITS] |
                                   sat_p[2][FIELD_BITS] | sat_d[FIELD_BITS];
      end
   end

   assign rsp_ch.valid = v_ff[STAGES-1];

   // no request enters while the plane is being renormalized
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |-> !norm.busy)
      else $error("request accepted during normalization");

   // a coefficient write always starts the normalizer
   a_write_starts: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> norm.busy)
      else $error("normalizer not started by csr write");

   // a degenerate plane leaves zero distance
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.degenerate) |-> (rsp_ch.signed_distance == '0))
      else $error("degenerate plane gave nonzero distance");

   // a stalled response stage keeps its request
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      (v_ff[STAGES-1] && !rsp_ch.ready) |=> v_ff[STAGES-1])
      else $error("stalled response dropped");

endmodule
